>>> rtl/core/uft_pkg.sv
// shared types and constants for the uart ring buffer controller
`default_nettype none

package uft_pkg;

  // ring depths and derived widths
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  // fixed payload widths
  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 9;

  // event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE    = 3'd0,
    CMD_TX_EMPTY   = 3'd1,
    CMD_TX_DONE    = 3'd2,
    CMD_HOST_WRITE = 3'd3,
    CMD_HOST_READ  = 3'd4
  } cmd_t;

  // per-cycle ring access request
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  // result flags held between memory read and output register
  typedef struct packed {
    logic tx_valid;
    logic rd_valid;
    logic accepted;
    logic notify;
    logic done;
  } res_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/uft_in_if.sv
// input channel: one event with its data byte
`default_nettype none

interface uft_in_if;
  logic                          valid;
  logic                          ready;
  logic [uft_pkg::CMD_W-1:0]     command;
  logic [uft_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/uft_out_if.sv
// output channel: one result item per event
`default_nettype none

interface uft_out_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_valid;
  logic [uft_pkg::BYTE_W-1:0]    tx_byte;
  logic                          rd_valid;
  logic [uft_pkg::BYTE_W-1:0]    rd_byte;
  logic                          write_accepted;
  logic                          rx_notify;
  logic                          tx_done;
  logic                          sending;
  logic [uft_pkg::LEVEL_W-1:0]   rx_level;
  logic [uft_pkg::LEVEL_W-1:0]   tx_level;

  modport source (
    output valid, output tx_valid, output tx_byte, output rd_valid, output rd_byte,
    output write_accepted, output rx_notify, output tx_done, output sending,
    output rx_level, output tx_level, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input rd_valid, input rd_byte,
    input write_accepted, input rx_notify, input tx_done, input sending,
    input rx_level, input tx_level, output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/uart_fifo_buffer_controller.sv
// top level: event decode, interrupt-enable flags and result staging
//
// Sits between a UART and a host and holds a receive ring and a transmit ring.
// in_ch carries one event per item: byte received, transmit data empty,
// transmit complete, host write or host read, with a data byte for the
// received-byte and host-write events. out_ch returns exactly one result per
// event: the byte handed to the transmitter, the byte popped for the host,
// the write acceptance, the receive notify and transmit done pulses, the
// sending flag and both ring levels as they stand after that event.
// One event is accepted per clock while out_ch keeps up. Its result passes
// through the registered ring memory read, staged with its flags, then the
// output register. Pointers, counts and flags update at the accept edge,
// so an event can read a slot written by the event just before it.
// When out_ch stalls, the output register and the one staged result fill
// and in_ch.ready drops until out_ch takes an item.
// Synchronous reset clears pointers, counts, enable flags and the sending
// flag at once; the ring memories are not cleared and need no sweep, so an
// event is accepted in the first cycle after reset.
`default_nettype none

module uart_fifo_buffer_controller (
  input  wire logic  clk,
  input  wire logic  rst,
  uft_in_if.sink     in_ch,
  uft_out_if.source  out_ch
);

  logic                          in_accept;
  uft_pkg::cmd_t                 cmd;
  uft_pkg::ring_ctl_t            rx_ctl;
  uft_pkg::ring_ctl_t            tx_ctl;
  logic [uft_pkg::BYTE_W-1:0]    rx_rd_data;
  logic [uft_pkg::BYTE_W-1:0]    tx_rd_data;
  logic [uft_pkg::RX_CW-1:0]     rx_count;
  logic [uft_pkg::TX_CW-1:0]     tx_count;
  logic                          tx_empty;
  logic                          tx_full;
  logic                          rx_empty;

  logic                          txe_en;
  logic                          txe_en_next;
  logic                          tc_en;
  logic                          tc_en_next;
  logic                          sending_flag;
  logic                          sending_flag_next;
  uft_pkg::res_flags_t           flags_next;

  logic                          p_valid;
  uft_pkg::res_flags_t           p_flags;
  logic                          out_valid;
  logic                          out_load;

  assign cmd      = uft_pkg::cmd_t'(in_ch.command);
  assign tx_empty = (tx_count == '0);
  assign tx_full  = (tx_count == uft_pkg::TX_CW'(uft_pkg::TX_DEPTH));
  assign rx_empty = (rx_count == '0);

  // handshake: staged result moves on when the output register is free
  assign out_load    = p_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !p_valid || out_load;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // rings
  uft_rx_ring u_rx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rx_ctl),
    .wr_data (in_ch.data_byte),
    .rd_data (rx_rd_data),
    .count   (rx_count)
  );

  uft_tx_ring u_tx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tx_ctl),
    .wr_data (in_ch.data_byte),
    .rd_data (tx_rd_data),
    .count   (tx_count)
  );

  // event decode: ring requests, flag updates and result flags
  always_comb begin
    rx_ctl            = '0;
    tx_ctl            = '0;
    flags_next        = '0;
    txe_en_next       = txe_en;
    tc_en_next        = tc_en;
    sending_flag_next = sending_flag;
    if (in_accept) begin
      unique case (cmd)
        uft_pkg::CMD_RX_BYTE: begin
          rx_ctl.push       = 1'b1;
          flags_next.notify = 1'b1;
        end
        uft_pkg::CMD_TX_EMPTY: begin
          if (txe_en) begin
            if (tx_empty) begin
              txe_en_next = 1'b0;
              tc_en_next  = 1'b1;
            end else begin
              sending_flag_next   = 1'b1;
              tx_ctl.pop          = 1'b1;
              flags_next.tx_valid = 1'b1;
            end
          end
        end
        uft_pkg::CMD_TX_DONE: begin
          if (tc_en) begin
            if (tx_empty) begin
              tc_en_next        = 1'b0;
              flags_next.done   = 1'b1;
              sending_flag_next = 1'b0;
            end else begin
              tx_ctl.pop          = 1'b1;
              flags_next.tx_valid = 1'b1;
            end
          end
        end
        uft_pkg::CMD_HOST_WRITE: begin
          txe_en_next = 1'b1;
          if (!tx_full) begin
            tx_ctl.push         = 1'b1;
            flags_next.accepted = 1'b1;
          end
        end
        uft_pkg::CMD_HOST_READ: begin
          if (!rx_empty) begin
            rx_ctl.pop          = 1'b1;
            flags_next.rd_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      txe_en       <= 1'b0;
      tc_en        <= 1'b0;
      sending_flag <= 1'b0;
    end else begin
      txe_en       <= txe_en_next;
      tc_en        <= tc_en_next;
      sending_flag <= sending_flag_next;
    end
  end

  // staged result while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_accept) begin
      p_valid <= 1'b1;
    end else if (out_load) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_flags <= flags_next;
    end
  end

  // output register; staged item is the latest accepted, so state is current
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.tx_valid       <= p_flags.tx_valid;
      out_ch.tx_byte        <= p_flags.tx_valid ? tx_rd_data : '0;
      out_ch.rd_valid       <= p_flags.rd_valid;
      out_ch.rd_byte        <= p_flags.rd_valid ? rx_rd_data : '0;
      out_ch.write_accepted <= p_flags.accepted;
      out_ch.rx_notify      <= p_flags.notify;
      out_ch.tx_done        <= p_flags.done;
      out_ch.sending        <= sending_flag;
      out_ch.rx_level       <= uft_pkg::LEVEL_W'(rx_count);
      out_ch.tx_level       <= uft_pkg::LEVEL_W'(tx_count);
    end
  end

  assign out_ch.valid = out_valid;

  // counts never pass the ring depths
  assert property (@(posedge clk) disable iff (rst)
    rx_count <= uft_pkg::RX_CW'(uft_pkg::RX_DEPTH) &&
    tx_count <= uft_pkg::TX_CW'(uft_pkg::TX_DEPTH))
    else $error("ring count above depth");

  // a single event never pops both rings, nor pushes both
  assert property (@(posedge clk) disable iff (rst)
    !(rx_ctl.pop && tx_ctl.pop) && !(rx_ctl.push && tx_ctl.push))
    else $error("both rings accessed by one event");

  // a done pulse always leaves the sending flag clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.tx_done |-> !out_ch.sending)
    else $error("done reported while still sending");

  // a staged result that cannot move blocks the input
  assert property (@(posedge clk) disable iff (rst)
    p_valid && out_valid && !out_ch.ready |=> p_valid && $stable(p_flags))
    else $error("staged result lost under stall");

  // the sending flag only rises on a data-empty event with bytes queued
  assert property (@(posedge clk) disable iff (rst)
    $rose(sending_flag) |-> $past(tx_ctl.pop))
    else $error("sending set without a transmit pop");

endmodule

`default_nettype wire

>>> rtl/core/uft_rx_ring.sv
// receive ring: byte memory, pointers and saturating fill count
`default_nettype none

module uft_rx_ring (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire uft_pkg::ring_ctl_t            ctl,
  input  wire logic [uft_pkg::BYTE_W-1:0]    wr_data,
  output logic [uft_pkg::BYTE_W-1:0]         rd_data,
  output logic [uft_pkg::RX_CW-1:0]          count
);

  logic [uft_pkg::BYTE_W-1:0] mem [uft_pkg::RX_DEPTH];
  logic [uft_pkg::RX_AW-1:0]  wr_ptr;
  logic [uft_pkg::RX_AW-1:0]  rd_ptr;
  logic [uft_pkg::RX_AW-1:0]  wr_ptr_inc;
  logic [uft_pkg::RX_AW-1:0]  rd_ptr_inc;
  logic                       full;

  // wrapping pointer increments
  assign wr_ptr_inc = (wr_ptr == uft_pkg::RX_AW'(uft_pkg::RX_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == uft_pkg::RX_AW'(uft_pkg::RX_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign full       = (count == uft_pkg::RX_CW'(uft_pkg::RX_DEPTH));

  // byte memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // pointers and count; overflow overwrites the oldest slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr_inc;
        if (!full) begin
          count <= count + 1'b1;
        end
      end else if (ctl.pop) begin
        rd_ptr <= rd_ptr_inc;
        count  <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uft_tx_ring.sv
// transmit ring: byte memory, pointers and fill count
`default_nettype none

module uft_tx_ring (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire uft_pkg::ring_ctl_t            ctl,
  input  wire logic [uft_pkg::BYTE_W-1:0]    wr_data,
  output logic [uft_pkg::BYTE_W-1:0]         rd_data,
  output logic [uft_pkg::TX_CW-1:0]          count
);

  logic [uft_pkg::BYTE_W-1:0] mem [uft_pkg::TX_DEPTH];
  logic [uft_pkg::TX_AW-1:0]  wr_ptr;
  logic [uft_pkg::TX_AW-1:0]  rd_ptr;
  logic [uft_pkg::TX_AW-1:0]  wr_ptr_inc;
  logic [uft_pkg::TX_AW-1:0]  rd_ptr_inc;

  // wrapping pointer increments
  assign wr_ptr_inc = (wr_ptr == uft_pkg::TX_AW'(uft_pkg::TX_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == uft_pkg::TX_AW'(uft_pkg::TX_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // byte memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // pointers and count; the controller only pushes when there is room
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr_inc;
        count  <= count + 1'b1;
      end else if (ctl.pop) begin
        rd_ptr <= rd_ptr_inc;
        count  <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for the uart ring buffer controller
`timescale 1ns / 100ps

module tb_top;
  import uft_pkg::*;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 8;

  // one result item as seen on the output channel
  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               rd_valid;
    logic [BYTE_W-1:0]  rd_byte;
    logic               write_accepted;
    logic               rx_notify;
    logic               tx_done;
    logic               sending;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } ring_result_t;

  // ring model plus the queue of results still owed by the block
  class uart_ring_predictor;
    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    logic [RX_AW-1:0]  rx_wr, rx_rd;
    logic [TX_AW-1:0]  tx_wr, tx_rd;
    logic [RX_CW-1:0]  rx_cnt;
    logic [TX_CW-1:0]  tx_cnt;
    logic              txe_en, tc_en, sending;
    ring_result_t      due_results[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      rx_cnt = '0;
      tx_cnt = '0;
      txe_en = 1'b0;
      tc_en = 1'b0;
      sending = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    // depths are powers of two, so the pointers wrap on their own width
    function void note_event(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] data);
      ring_result_t r;
      r = '0;
      case (code)
        CMD_RX_BYTE: begin
          rx_ring[rx_wr] = data;
          rx_wr = rx_wr + 1'b1;
          if (rx_cnt < RX_DEPTH) rx_cnt = rx_cnt + 1'b1;
          r.rx_notify = 1'b1;
        end
        CMD_TX_EMPTY: begin
          if (txe_en) begin
            if (tx_cnt == 0) begin
              txe_en = 1'b0;
              tc_en = 1'b1;
            end else begin
              sending = 1'b1;
              r.tx_valid = 1'b1;
              r.tx_byte = tx_ring[tx_rd];
              tx_rd = tx_rd + 1'b1;
              tx_cnt = tx_cnt - 1'b1;
            end
          end
        end
        CMD_TX_DONE: begin
          if (tc_en) begin
            if (tx_cnt == 0) begin
              tc_en = 1'b0;
              sending = 1'b0;
              r.tx_done = 1'b1;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = tx_ring[tx_rd];
              tx_rd = tx_rd + 1'b1;
              tx_cnt = tx_cnt - 1'b1;
            end
          end
        end
        CMD_HOST_WRITE: begin
          if (tx_cnt < TX_DEPTH) begin
            tx_ring[tx_wr] = data;
            tx_wr = tx_wr + 1'b1;
            tx_cnt = tx_cnt + 1'b1;
            r.write_accepted = 1'b1;
          end
          // a refused write still turns on data-empty handling
          txe_en = 1'b1;
        end
        CMD_HOST_READ: begin
          if (rx_cnt != 0) begin
            r.rd_valid = 1'b1;
            r.rd_byte = rx_ring[rx_rd];
            rx_rd = rx_rd + 1'b1;
            rx_cnt = rx_cnt - 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.sending = sending;
      r.rx_level = LEVEL_W'(rx_cnt);
      r.tx_level = LEVEL_W'(tx_cnt);
      due_results.push_back(r);
    endfunction

    // compare one result with the oldest one owed
    function void check_result(input ring_result_t got);
      ring_result_t want;
      string bad;
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d arrived with none pending: rx_level %0d tx_level %0d",
                   checked, got.rx_level, got.tx_level);
        return;
      end
      want = due_results.pop_front();
      bad = "";
      if (got.tx_valid !== want.tx_valid) bad = {bad, " tx_valid"};
      if (got.tx_byte !== want.tx_byte) bad = {bad, " tx_byte"};
      if (got.rd_valid !== want.rd_valid) bad = {bad, " rd_valid"};
      if (got.rd_byte !== want.rd_byte) bad = {bad, " rd_byte"};
      if (got.write_accepted !== want.write_accepted) bad = {bad, " write_accepted"};
      if (got.rx_notify !== want.rx_notify) bad = {bad, " rx_notify"};
      if (got.tx_done !== want.tx_done) bad = {bad, " tx_done"};
      if (got.sending !== want.sending) bad = {bad, " sending"};
      if (got.rx_level !== want.rx_level) bad = {bad, " rx_level"};
      if (got.tx_level !== want.tx_level) bad = {bad, " tx_level"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d wrong in%s", checked, bad);
          $display("  expected tx %b/%h rd %b/%h acc %b ntf %b done %b snd %b lvl %0d/%0d",
                   want.tx_valid, want.tx_byte, want.rd_valid, want.rd_byte,
                   want.write_accepted, want.rx_notify, want.tx_done, want.sending,
                   want.rx_level, want.tx_level);
          $display("  actual   tx %b/%h rd %b/%h acc %b ntf %b done %b snd %b lvl %0d/%0d",
                   got.tx_valid, got.tx_byte, got.rd_valid, got.rd_byte,
                   got.write_accepted, got.rx_notify, got.tx_done, got.sending,
                   got.rx_level, got.tx_level);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_gaps = 1'b0;
  uart_ring_predictor model;

  uft_in_if  in_ch ();
  uft_out_if out_ch ();

  uart_fifo_buffer_controller uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // weighted command pick, with a small share of unused codes
  function automatic logic [CMD_W-1:0] pick_cmd(input int w_rx, input int w_txe,
                                                input int w_tc, input int w_wr,
                                                input int w_rd);
    int pick;
    pick = $urandom_range(0, w_rx + w_txe + w_tc + w_wr + w_rd + 1);
    if (pick < w_rx) return CMD_RX_BYTE;
    pick -= w_rx;
    if (pick < w_txe) return CMD_TX_EMPTY;
    pick -= w_txe;
    if (pick < w_tc) return CMD_TX_DONE;
    pick -= w_tc;
    if (pick < w_wr) return CMD_HOST_WRITE;
    pick -= w_wr;
    if (pick < w_rd) return CMD_HOST_READ;
    return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  // present one event and wait until the block takes it
  task automatic send_event(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] data);
    int idle;
    idle = no_gaps ? 0 : idle_len();
    @(negedge clk);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= code;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    model.note_event(code, data);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (model.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int w_rx, input int w_txe, input int w_tc,
                           input int w_wr, input int w_rd, input bit quiet);
    no_gaps = quiet;
    repeat (count)
      send_event(pick_cmd(w_rx, w_txe, w_tc, w_wr, w_rd), BYTE_W'($urandom_range(0, 255)));
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  // output side: runs of ready broken by random stalls
  initial begin
    int run;
    int stall;
    out_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      run = no_gaps ? 40 : $urandom_range(1, 12);
      repeat (run) @(negedge clk) out_ch.ready <= 1'b1;
      stall = no_gaps ? 0 : idle_len();
      repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
    end
  end

  // take each result item at the rising edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      model.check_result('{out_ch.tx_valid, out_ch.tx_byte, out_ch.rd_valid, out_ch.rd_byte,
                           out_ch.write_accepted, out_ch.rx_notify, out_ch.tx_done,
                           out_ch.sending, out_ch.rx_level, out_ch.tx_level});
  end

  // stimulus
  initial begin
    int c;
    model = new();
    in_ch.valid = 1'b0;
    in_ch.command = CMD_RX_BYTE;
    in_ch.data_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty read, disabled transmit events, unused codes
    send_event(CMD_HOST_READ, 8'h00);
    send_event(CMD_TX_EMPTY, 8'h00);
    send_event(CMD_TX_DONE, 8'h00);
    for (c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_event(c[CMD_W-1:0], 8'hFF);
    // receive extremes and read them back
    send_event(CMD_RX_BYTE, 8'h00);
    send_event(CMD_RX_BYTE, 8'hFF);
    send_event(CMD_HOST_READ, 8'h00);
    send_event(CMD_HOST_READ, 8'h00);
    // queue three, drain them, then switch to completion handling
    send_event(CMD_HOST_WRITE, 8'h00);
    send_event(CMD_HOST_WRITE, 8'hFF);
    send_event(CMD_HOST_WRITE, 8'h5A);
    repeat (4) send_event(CMD_TX_EMPTY, 8'h00);
    // completion with a byte pending, then completion on an empty ring
    send_event(CMD_HOST_WRITE, 8'hA5);
    send_event(CMD_TX_DONE, 8'h00);
    send_event(CMD_TX_DONE, 8'h00);
    send_event(CMD_TX_DONE, 8'h00);
    wait_for_results();

    // random phases: free mix, then filling and draining each ring past full
    run_phase(100, 25, 20, 15, 20, 20, 1'b1);
    run_phase(100, 25, 20, 15, 20, 20, 1'b0);
    run_phase(380, 90, 2, 1, 2, 5, 1'b0);
    run_phase(360, 8, 4, 4, 4, 80, 1'b0);
    run_phase(380, 2, 5, 2, 90, 1, 1'b0);
    run_phase(300, 4, 50, 40, 3, 3, 1'b0);
    run_phase(60, 25, 20, 15, 20, 20, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.due_results.size() == 0)
      $display("uart_fifo_buffer_controller test passed");
    else
      $display("uart_fifo_buffer_controller test failed");
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("uart_fifo_buffer_controller test failed");
    $finish;
  end

endmodule
